// ===== design/date_time_offset_unit_top_defines.svh =====
// Assertion macros shared by the date/time offset unit RTL.
`ifndef DATE_TIME_OFFSET_UNIT_TOP_DEFINES_SVH
`define DATE_TIME_OFFSET_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DTOU_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DTOU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dtou_pkg.sv =====
// Types, codes, microprogram and calendar helpers of the date/time offset unit.
`default_nettype none

package dtou_pkg;

    localparam int SPAN_DAY_BITS_DEF = 16;

    // action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_ADD  = 2'd1;
    localparam logic [1:0] ACT_SUB  = 2'd2;

    // month codes used by the calendar helpers
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // year / 100 by reciprocal: floor(y * K / 2^23), exact for 16-bit y
    localparam logic [16:0] CENT_K  = 17'd83887;
    localparam int          CENT_SH = 23;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ADD_S,
        OP_ADD_M,
        OP_ADD_H,
        OP_SUB_S,
        OP_SUB_M,
        OP_SUB_H,
        OP_LEAP_Q,
        OP_LEAP_F,
        OP_F_LEN,
        OP_F_STEP,
        OP_B_LEN,
        OP_B_STEP,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        CND_NEXT,
        CND_GOTO,
        CND_ZERO,
        CND_WAIT
    } cond_t;

    localparam int UPC_W = 5;

    localparam logic [UPC_W-1:0] A_IDLE  = 5'd0;
    localparam logic [UPC_W-1:0] A_LOAD  = 5'd1;
    localparam logic [UPC_W-1:0] A_ADD   = 5'd2;
    localparam logic [UPC_W-1:0] A_FLOOP = 5'd5;
    localparam logic [UPC_W-1:0] A_SUB   = 5'd9;
    localparam logic [UPC_W-1:0] A_BLOOP = 5'd12;
    localparam logic [UPC_W-1:0] A_DONE  = 5'd16;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    // sequencer inputs
    typedef struct packed {
        logic       take;
        logic [1:0] action;
        logic       n_zero;
    } seq_in_t;

    // microprogram ROM
    function automatic uword_t urom(input logic [UPC_W-1:0] a);
        uword_t w;
        w = '{op: OP_NOP, cond: CND_GOTO, target: A_IDLE};
        case (a)
            5'd0:  w = '{op: OP_NOP,    cond: CND_WAIT, target: A_IDLE};
            5'd1:  w = '{op: OP_LOAD,   cond: CND_GOTO, target: A_DONE};
            5'd2:  w = '{op: OP_ADD_S,  cond: CND_NEXT, target: A_IDLE};
            5'd3:  w = '{op: OP_ADD_M,  cond: CND_NEXT, target: A_IDLE};
            5'd4:  w = '{op: OP_ADD_H,  cond: CND_NEXT, target: A_IDLE};
            5'd5:  w = '{op: OP_LEAP_Q, cond: CND_ZERO, target: A_DONE};
            5'd6:  w = '{op: OP_LEAP_F, cond: CND_NEXT, target: A_IDLE};
            5'd7:  w = '{op: OP_F_LEN,  cond: CND_NEXT, target: A_IDLE};
            5'd8:  w = '{op: OP_F_STEP, cond: CND_GOTO, target: A_FLOOP};
            5'd9:  w = '{op: OP_SUB_S,  cond: CND_NEXT, target: A_IDLE};
            5'd10: w = '{op: OP_SUB_M,  cond: CND_NEXT, target: A_IDLE};
            5'd11: w = '{op: OP_SUB_H,  cond: CND_NEXT, target: A_IDLE};
            5'd12: w = '{op: OP_LEAP_Q, cond: CND_ZERO, target: A_DONE};
            5'd13: w = '{op: OP_LEAP_F, cond: CND_NEXT, target: A_IDLE};
            5'd14: w = '{op: OP_B_LEN,  cond: CND_NEXT, target: A_IDLE};
            5'd15: w = '{op: OP_B_STEP, cond: CND_GOTO, target: A_BLOOP};
            5'd16: w = '{op: OP_EMIT,   cond: CND_GOTO, target: A_IDLE};
            default: w = '{op: OP_NOP,  cond: CND_GOTO, target: A_IDLE};
        endcase
        return w;
    endfunction

    // days in month; months outside 1..12 count as 31
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        case (m) inside
            MON_FEB:                          len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default:                          len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== design/date_time_offset_unit_top.sv =====
// Date/time offset unit: microcoded sequencer plus calendar datapath.
//
// Holds one date and time of day. A transaction is taken when start is high
// and busy is low; busy then stays high until the result has been shown.
// The result (the stored date and time after the step) is valid on the now_*
// ports for the single cycle in which done is high; nothing can hold it off,
// so the receiver must take it then. A load goes from accept through the load
// step to done; an unused action goes straight to done. Add and subtract step
// through the seconds, minutes and hours, then run a loop (century quotient,
// leap flag, month length, month step) that advances or retreats the date by
// up to one whole month per pass, and leave it for done once no days remain.
`default_nettype none

module date_time_offset_unit_top
    import dtou_pkg::*;
#(
    parameter int SPAN_DAY_BITS = SPAN_DAY_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               action,
    input  wire logic [4:0]               load_hour,
    input  wire logic [5:0]               load_minute,
    input  wire logic [5:0]               load_second,
    input  wire logic [4:0]               load_day,
    input  wire logic [3:0]               load_month,
    input  wire logic [15:0]              load_year,
    input  wire logic [SPAN_DAY_BITS-1:0] span_days,
    input  wire logic [4:0]               span_hours,
    input  wire logic [5:0]               span_minutes,
    input  wire logic [5:0]               span_seconds,
    output logic                          done,
    output logic [4:0]                    now_hour,
    output logic [5:0]                    now_minute,
    output logic [5:0]                    now_second,
    output logic [4:0]                    now_day,
    output logic [3:0]                    now_month,
    output logic [15:0]                   now_year
);

`include "date_time_offset_unit_top_defines.svh"

    logic    take;
    logic    n_zero;
    op_t     op;
    seq_in_t sin;

    assign take = start && !busy;

    assign sin = '{take: take, action: action, n_zero: n_zero};

    dtou_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sin   (sin),
        .op    (op),
        .busy  (busy)
    );

    dtou_datapath #(
        .SPAN_DAY_BITS (SPAN_DAY_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .op           (op),
        .load_hour    (load_hour),
        .load_minute  (load_minute),
        .load_second  (load_second),
        .load_day     (load_day),
        .load_month   (load_month),
        .load_year    (load_year),
        .span_days    (span_days),
        .span_hours   (span_hours),
        .span_minutes (span_minutes),
        .span_seconds (span_seconds),
        .n_zero       (n_zero),
        .hour         (now_hour),
        .minute       (now_minute),
        .second       (now_second),
        .day          (now_day),
        .month        (now_month),
        .year         (now_year)
    );

    assign done = (op == OP_EMIT);

    `DTOU_ASSERT_NEXT(a_take_busy, clk, rst_n, take, busy, "accepted transaction not busy")
    `DTOU_ASSERT_SAME(a_done_busy, clk, rst_n, done, busy, "result outside a transaction")
    `DTOU_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy && !done, "no return to idle")
    `DTOU_ASSERT_NEXT(a_idle_hold, clk, rst_n, !busy && !start,
        $stable(now_year) && $stable(now_month) && $stable(now_day) &&
        $stable(now_hour) && $stable(now_minute) && $stable(now_second),
        "stored value changed while idle")

endmodule

`default_nettype wire

// ===== design/dtou_sequencer.sv =====
// Microprogram counter, control store lookup and jump logic.
`default_nettype none

module dtou_sequencer
    import dtou_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire seq_in_t sin,
    output op_t          op,
    output logic         busy
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [UPC_W-1:0] upc_inc;
    uword_t           uw;

    function automatic logic [UPC_W-1:0] dispatch(input logic [1:0] act);
        logic [UPC_W-1:0] a;
        a = A_DONE;
        unique case (act)
            ACT_LOAD: a = A_LOAD;
            ACT_ADD:  a = A_ADD;
            ACT_SUB:  a = A_SUB;
            default:  a = A_DONE;
        endcase
        return a;
    endfunction

    assign uw      = urom(upc_reg);
    assign upc_inc = UPC_W'(upc_reg + 1'b1);

    always_comb
    begin
        upc_next = upc_inc;
        unique case (uw.cond)
            CND_NEXT: upc_next = upc_inc;
            CND_GOTO: upc_next = uw.target;
            CND_ZERO: upc_next = sin.n_zero ? uw.target : upc_inc;
            CND_WAIT: upc_next = sin.take ? dispatch(sin.action) : upc_reg;
            default:  upc_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= A_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign op   = uw.op;
    assign busy = (upc_reg != A_IDLE);

endmodule

`default_nettype wire

// ===== design/dtou_datapath.sv =====
// Date/time registers, operand latches and the per-step arithmetic.
`default_nettype none

module dtou_datapath
    import dtou_pkg::*;
#(
    parameter int SPAN_DAY_BITS = SPAN_DAY_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     take,
    input  wire op_t                      op,
    input  wire logic [4:0]               load_hour,
    input  wire logic [5:0]               load_minute,
    input  wire logic [5:0]               load_second,
    input  wire logic [4:0]               load_day,
    input  wire logic [3:0]               load_month,
    input  wire logic [15:0]              load_year,
    input  wire logic [SPAN_DAY_BITS-1:0] span_days,
    input  wire logic [4:0]               span_hours,
    input  wire logic [5:0]               span_minutes,
    input  wire logic [5:0]               span_seconds,
    output logic                          n_zero,
    output logic [4:0]                    hour,
    output logic [5:0]                    minute,
    output logic [5:0]                    second,
    output logic [4:0]                    day,
    output logic [3:0]                    month,
    output logic [15:0]                   year
);

    localparam int NW = SPAN_DAY_BITS + 1;

    // stored date and time
    logic [4:0]  hour_reg,   hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [4:0]  day_reg,    day_next;
    logic [3:0]  month_reg,  month_next;
    logic [15:0] year_reg,   year_next;

    // transaction operands
    logic [4:0]  ld_hour_reg;
    logic [5:0]  ld_minute_reg;
    logic [5:0]  ld_second_reg;
    logic [4:0]  ld_day_reg;
    logic [3:0]  ld_month_reg;
    logic [15:0] ld_year_reg;
    logic [4:0]  sh_reg;
    logic [5:0]  sm_reg;
    logic [5:0]  ss_reg;

    // work registers
    logic [NW-1:0] n_reg,     n_next;
    logic [1:0]    carry_reg, carry_next;
    logic [9:0]    q_reg,     q_next;
    logic          leap_reg,  leap_next;
    logic [5:0]    gap_reg,   gap_next;
    logic [4:0]    plen_reg,  plen_next;
    logic [3:0]    pmon_reg,  pmon_next;
    logic          pwrap_reg, pwrap_next;

    logic [6:0]  sum7;
    logic [7:0]  sum8;
    logic [6:0]  dif7;
    logic [5:0]  dif6;
    logic [32:0] cent_prod;
    logic [15:0] cent_x100;
    logic [4:0]  cur_len;
    logic        n_ge_gap;

    assign cent_prod = year_reg * CENT_K;
    assign cent_x100 = 16'({q_reg, 6'b0} + {1'b0, q_reg, 5'b0} + {4'b0, q_reg, 2'b0});
    assign cur_len   = month_len(month_reg, leap_reg);
    assign n_ge_gap  = (n_reg >= NW'(gap_reg));

    always_comb
    begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        n_next      = n_reg;
        carry_next  = carry_reg;
        q_next      = q_reg;
        leap_next   = leap_reg;
        gap_next    = gap_reg;
        plen_next   = plen_reg;
        pmon_next   = pmon_reg;
        pwrap_next  = pwrap_reg;
        sum7        = '0;
        sum8        = '0;
        dif7        = '0;
        dif6        = '0;

        if (take)
        begin
            n_next = NW'(span_days);
        end

        unique case (op) inside
            OP_NOP, OP_EMIT:
            begin
            end
            OP_LOAD:
            begin
                hour_next   = ld_hour_reg;
                minute_next = ld_minute_reg;
                second_next = ld_second_reg;
                day_next    = ld_day_reg;
                month_next  = ld_month_reg;
                year_next   = ld_year_reg;
            end
            OP_ADD_S:
            begin
                sum7 = {1'b0, second_reg} + {1'b0, ss_reg};
                if (sum7 >= 7'd120)
                begin
                    second_next = 6'(sum7 - 7'd120);
                    carry_next  = 2'd2;
                end
                else if (sum7 >= 7'd60)
                begin
                    second_next = 6'(sum7 - 7'd60);
                    carry_next  = 2'd1;
                end
                else
                begin
                    second_next = sum7[5:0];
                    carry_next  = 2'd0;
                end
            end
            OP_ADD_M:
            begin
                sum8 = {2'b0, minute_reg} + {2'b0, sm_reg} + {6'b0, carry_reg};
                if (sum8 >= 8'd120)
                begin
                    minute_next = 6'(sum8 - 8'd120);
                    carry_next  = 2'd2;
                end
                else if (sum8 >= 8'd60)
                begin
                    minute_next = 6'(sum8 - 8'd60);
                    carry_next  = 2'd1;
                end
                else
                begin
                    minute_next = sum8[5:0];
                    carry_next  = 2'd0;
                end
            end
            OP_ADD_H:
            begin
                // hour overflow wraps mod 24 and carries a single day
                sum7 = {2'b0, hour_reg} + {2'b0, sh_reg} + {5'b0, carry_reg};
                if (sum7 >= 7'd48)
                begin
                    hour_next = 5'(sum7 - 7'd48);
                    n_next    = NW'(n_reg + 1'b1);
                end
                else if (sum7 >= 7'd24)
                begin
                    hour_next = 5'(sum7 - 7'd24);
                    n_next    = NW'(n_reg + 1'b1);
                end
                else
                begin
                    hour_next = sum7[4:0];
                end
            end
            OP_SUB_S:
            begin
                dif7 = {1'b0, second_reg} - {1'b0, ss_reg};
                if (dif7[6])
                begin
                    second_next = 6'(dif7 + 7'd60);
                    carry_next  = 2'd1;
                end
                else
                begin
                    second_next = dif7[5:0];
                    carry_next  = 2'd0;
                end
            end
            OP_SUB_M:
            begin
                dif7 = {1'b0, minute_reg} - {1'b0, sm_reg} - {6'b0, carry_reg[0]};
                if (dif7[6])
                begin
                    minute_next = 6'(dif7 + 7'd60);
                    carry_next  = 2'd1;
                end
                else
                begin
                    minute_next = dif7[5:0];
                    carry_next  = 2'd0;
                end
            end
            OP_SUB_H:
            begin
                dif6 = {1'b0, hour_reg} - {1'b0, sh_reg} - {5'b0, carry_reg[0]};
                if (dif6[5])
                begin
                    hour_next = 5'(dif6 + 6'd24);
                    n_next    = NW'(n_reg + 1'b1);
                end
                else
                begin
                    hour_next = dif6[4:0];
                end
            end
            OP_LEAP_Q:
            begin
                q_next = cent_prod[CENT_SH +: 10];
            end
            OP_LEAP_F:
            begin
                leap_next = (year_reg[1:0] == 2'b00) &&
                            ((cent_x100 != year_reg) || (q_reg[1:0] == 2'b00));
            end
            OP_F_LEN:
            begin
                // days to consume before rolling into the next month
                if (day_reg > cur_len)
                begin
                    gap_next = 6'd1;
                end
                else
                begin
                    gap_next = 6'({1'b0, cur_len} - {1'b0, day_reg} + 6'd1);
                end
            end
            OP_F_STEP:
            begin
                if (n_ge_gap)
                begin
                    n_next   = NW'(n_reg - NW'(gap_reg));
                    day_next = 5'd1;
                    if (month_reg >= MON_DEC)
                    begin
                        month_next = MON_JAN;
                        year_next  = 16'(year_reg + 1'b1);
                    end
                    else
                    begin
                        month_next = 4'(month_reg + 1'b1);
                    end
                end
                else
                begin
                    day_next = 5'(day_reg + n_reg[4:0]);
                    n_next   = '0;
                end
            end
            OP_B_LEN:
            begin
                if (month_reg <= MON_JAN)
                begin
                    pmon_next  = MON_DEC;
                    pwrap_next = 1'b1;
                end
                else
                begin
                    pmon_next  = 4'(month_reg - 1'b1);
                    pwrap_next = 1'b0;
                end
                plen_next = month_len(pmon_next, leap_reg);
                gap_next  = (day_reg == 5'd0) ? 6'd1 : {1'b0, day_reg};
            end
            OP_B_STEP:
            begin
                if (n_ge_gap)
                begin
                    n_next     = NW'(n_reg - NW'(gap_reg));
                    month_next = pmon_reg;
                    year_next  = 16'(year_reg - {15'b0, pwrap_reg});
                    // day zero lands one short of the previous month's end
                    day_next   = (day_reg == 5'd0) ? 5'(plen_reg - 1'b1) : plen_reg;
                end
                else
                begin
                    day_next = 5'(day_reg - n_reg[4:0]);
                    n_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg   <= 5'd0;
            minute_reg <= 6'd0;
            second_reg <= 6'd0;
            day_reg    <= 5'd1;
            month_reg  <= 4'd1;
            year_reg   <= 16'd0;
        end
        else
        begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ld_hour_reg   <= load_hour;
            ld_minute_reg <= load_minute;
            ld_second_reg <= load_second;
            ld_day_reg    <= load_day;
            ld_month_reg  <= load_month;
            ld_year_reg   <= load_year;
            sh_reg        <= span_hours;
            sm_reg        <= span_minutes;
            ss_reg        <= span_seconds;
        end
        n_reg     <= n_next;
        carry_reg <= carry_next;
        q_reg     <= q_next;
        leap_reg  <= leap_next;
        gap_reg   <= gap_next;
        plen_reg  <= plen_next;
        pmon_reg  <= pmon_next;
        pwrap_reg <= pwrap_next;
    end

    assign n_zero = (n_reg == '0);
    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;
    assign day    = day_reg;
    assign month  = month_reg;
    assign year   = year_reg;

endmodule

`default_nettype wire
